// ===== design/drdf_pkg.sv =====
// Package for the detection row decode filter.
// Holds the row layout constants, register indexes and the structs shared
// between the top level and the row core. No dependencies.
package drdf_pkg;

  // Row layout.
  localparam int unsigned RowColumns   = 22;
  localparam int unsigned CornerValues = 8;
  localparam int unsigned ConfColumn   = 8;
  localparam int unsigned ColorColumn  = 9;
  localparam int unsigned ClassColumn  = 13;
  localparam int unsigned ClassCount   = 9;

  // Field widths.
  localparam int unsigned ValueWidth  = 20;
  localparam int unsigned CornerWidth = 22;
  localparam int unsigned ScaleWidth  = 16;
  localparam int unsigned ColWidth    = 5;
  localparam int unsigned ClassWidth  = 4;
  localparam int unsigned ColorWidth  = 2;
  localparam int unsigned CfgIdxWidth = 3;

  // Scaling: Q12.8 times Q4.12, rounded back to Q.8.
  localparam int unsigned ScaleFrac  = 12;
  localparam int unsigned ProdWidth  = ValueWidth + ScaleWidth + 1;
  localparam int unsigned ShiftWidth = ProdWidth - ScaleFrac;

  // Stream widths, padded to whole bytes.
  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 208;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgLogitThreshold = 3'd0,
    CfgAcceptEnable   = 3'd1,
    CfgTargetColor    = 3'd2,
    CfgSwapColors     = 3'd3,
    CfgScaleHoriz     = 3'd4,
    CfgScaleVert      = 3'd5
  } cfg_reg_e;

  // Reset values of the registers.
  localparam logic [ScaleWidth-1:0] ScaleReset = 16'd4096;

  // Color argmax codes; grey and purple have bit 1 set.
  localparam logic [ColorWidth-1:0] ColorBlue = 2'd0;
  localparam logic [ColorWidth-1:0] ColorRed  = 2'd1;

  // Configuration as seen by the row core.
  typedef struct packed {
    logic signed [ValueWidth-1:0] conf_threshold;
    logic                         accept_enable;
    logic                         target_color;
    logic                         swap_colors;
    logic [ScaleWidth-1:0]        scale_horizontal;
    logic [ScaleWidth-1:0]        scale_vertical;
  } cfg_t;

  // One decoded detection; corners[0] is top_left_x, corners[7] top_right_y.
  typedef struct packed {
    logic [ClassWidth-1:0]                      class_index;
    logic                                       kept_color;
    logic [ValueWidth-1:0]                      confidence_logit;
    logic [CornerValues-1:0][CornerWidth-1:0]   corners;
  } result_t;

endpackage

// ===== design/drdf_corner_scale.sv =====
// Corner coordinate scaler: multiplies a Q12.8 value by an unsigned Q4.12
// scale, rounds to Q.8 and saturates to signed Q14.8. Uses drdf_pkg.
module drdf_corner_scale (
  input  logic signed [drdf_pkg::ValueWidth-1:0]  value_i,
  input  logic        [drdf_pkg::ScaleWidth-1:0]  scale_i,
  output logic signed [drdf_pkg::CornerWidth-1:0] corner_o
);

  localparam int unsigned PW = drdf_pkg::ProdWidth;
  localparam int unsigned SW = drdf_pkg::ShiftWidth;
  localparam int unsigned CW = drdf_pkg::CornerWidth;

  localparam logic signed [SW-1:0] SatMax = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SatMin = SW'(-(64'sd1 <<< (CW - 1)));
  localparam logic signed [PW-1:0] Half   = PW'(64'sd1 <<< (drdf_pkg::ScaleFrac - 1));

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rounded;
  logic signed [SW-1:0] shifted;

  // Signed product with the scale zero-extended, then round half up.
  assign prod    = value_i * $signed({1'b0, scale_i});
  assign rounded = prod + Half;
  assign shifted = rounded[PW-1:drdf_pkg::ScaleFrac];

  // Clamp to the Q14.8 range.
  always_comb begin
    if (shifted > SatMax) begin
      corner_o = SatMax[CW-1:0];
    end else if (shifted < SatMin) begin
      corner_o = SatMin[CW-1:0];
    end else begin
      corner_o = shifted[CW-1:0];
    end
  end

endmodule

// ===== design/drdf_row_core.sv =====
// Row core: tracks the column of each item, stores scaled corners, runs the
// color and class argmax and decides at the last column whether the row is
// kept. Uses drdf_pkg and drdf_corner_scale.
module drdf_row_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   item_valid_i,
  input  logic signed [drdf_pkg::ValueWidth-1:0] value_i,
  input  logic                                   row_first_i,
  input  drdf_pkg::cfg_t                         cfg_i,
  output logic                                   emit_o,
  output drdf_pkg::result_t                      result_o
);

  localparam int unsigned VW = drdf_pkg::ValueWidth;
  localparam int unsigned CL = drdf_pkg::ColWidth;
  localparam logic [CL-1:0] LastCol   = CL'(drdf_pkg::RowColumns - 1);
  localparam logic [CL-1:0] ConfCol   = CL'(drdf_pkg::ConfColumn);
  localparam logic [CL-1:0] ColorCol  = CL'(drdf_pkg::ColorColumn);
  localparam logic [CL-1:0] ClassCol  = CL'(drdf_pkg::ClassColumn);
  localparam logic [CL-1:0] CornerEnd = CL'(drdf_pkg::CornerValues);

  logic [CL-1:0]                        col_cnt_q, col_cnt_d;
  logic [CL-1:0]                        col;
  logic signed [VW-1:0]                 conf_q, conf_d;
  logic signed [VW-1:0]                 color_val_q, color_val_d;
  logic [drdf_pkg::ColorWidth-1:0]      color_idx_q, color_idx_d;
  logic signed [VW-1:0]                 class_val_q, class_val_d;
  logic [drdf_pkg::ClassWidth-1:0]      class_idx_q, class_idx_d;
  logic                                 rej_q, rej_d;
  logic [drdf_pkg::CornerWidth-1:0]     corner_q [drdf_pkg::CornerValues];
  logic signed [drdf_pkg::CornerWidth-1:0] scaled;
  logic [drdf_pkg::ScaleWidth-1:0]      scale_sel;
  logic                                 kept;

  // Column of the current item; a row start forces column 0.
  assign col = row_first_i ? '0 : col_cnt_q;

  // Odd columns are y coordinates.
  assign scale_sel = col[0] ? cfg_i.scale_vertical : cfg_i.scale_horizontal;

  drdf_corner_scale u_scale (
    .value_i  (value_i),
    .scale_i  (scale_sel),
    .corner_o (scaled)
  );

  // Next-state logic for the row trackers.
  always_comb begin
    col_cnt_d   = col_cnt_q;
    conf_d      = conf_q;
    color_val_d = color_val_q;
    color_idx_d = color_idx_q;
    class_val_d = class_val_q;
    class_idx_d = class_idx_q;
    rej_d       = rej_q;
    if (item_valid_i) begin
      col_cnt_d = (col == LastCol) ? '0 : col + 1'b1;
      if (col == '0) begin
        rej_d = 1'b0;
      end
      if (col == ConfCol) begin
        conf_d = value_i;
        if (value_i < cfg_i.conf_threshold) begin
          rej_d = 1'b1;
        end
      end
      // Color argmax over columns 9 to 12, first maximum wins.
      if (col >= ColorCol && col < ClassCol) begin
        if (col == ColorCol || value_i > color_val_q) begin
          color_val_d = value_i;
          color_idx_d = drdf_pkg::ColorWidth'(col - ColorCol);
        end
      end
      // Class argmax over columns 13 to 21, first maximum wins.
      if (col >= ClassCol) begin
        if (col == ClassCol || value_i > class_val_q) begin
          class_val_d = value_i;
          class_idx_d = drdf_pkg::ClassWidth'(col - ClassCol);
        end
      end
    end
  end

  // Row decision at the last column.
  assign kept   = color_idx_q[0] ^ cfg_i.swap_colors;
  assign emit_o = item_valid_i && (col == LastCol) && !rej_q && cfg_i.accept_enable
                  && !color_idx_q[1] && (kept == cfg_i.target_color);

  always_comb begin
    for (int i = 0; i < drdf_pkg::CornerValues; i++) begin
      result_o.corners[i] = corner_q[i];
    end
    result_o.confidence_logit = conf_q;
    result_o.kept_color       = kept;
    result_o.class_index      = class_idx_d;
  end

  // Control and tracker registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      conf_q      <= '0;
      color_val_q <= '0;
      color_idx_q <= '0;
      class_val_q <= '0;
      class_idx_q <= '0;
      rej_q       <= 1'b0;
    end else begin
      col_cnt_q   <= col_cnt_d;
      conf_q      <= conf_d;
      color_val_q <= color_val_d;
      color_idx_q <= color_idx_d;
      class_val_q <= class_val_d;
      class_idx_q <= class_idx_d;
      rej_q       <= rej_d;
    end
  end

  // Corner store, written once per corner column.
  always_ff @(posedge clk_i) begin
    if (item_valid_i && col < CornerEnd) begin
      corner_q[col[2:0]] <= scaled;
    end
  end

`ifndef SYNTHESIS
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_cnt_q <= LastCol)
    else $error("column count out of range");

  a_emit_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (item_valid_i && col == LastCol))
    else $error("result outside the last column");

  a_row_start_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && col == '0) |=> !rej_q)
    else $error("reject flag not cleared at row start");

  a_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && col == LastCol) |=> col_cnt_q == '0)
    else $error("column count did not wrap after the last column");
`endif

endmodule

// ===== design/detection_row_decode_filter.sv =====
// Top level of the detection row decode filter: input register, config
// registers, row core and result register. Uses drdf_pkg and drdf_row_core.
//
// Usage:
// - s_axis carries one row value per item (tdata) and a row-start flag
//   (tuser). A row is 22 items: 8 corner coordinates, the confidence logit,
//   4 color logits and 9 class logits.
// - m_axis carries one decoded detection for each row that is kept; rows
//   that fail the enable, threshold or color checks give no item.
// - cfg writes one register per handshake; cfg_ready_o is always high.
//   Registers are to be written only while no row item is in flight (the
//   block does not enforce this).
// Timing: an item is registered on acceptance and processed once the result
// register is free, which holds a kept row's result for m_axis. One item
// is taken every cycle unless m_axis stalls, set by the single input stage.
// Stalls: when m_axis holds a result and tready is low, the processing stage
// waits, the input register fills and s_axis_tready drops; no item is lost.
// Reset: clears the column count, row trackers, valids and restores register
// defaults (threshold 0, enable 1, target blue, no swap, unity scales).
module detection_row_decode_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: value [19:0]; tuser: row_first [0]
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [drdf_pkg::InDataWidth-1:0]      s_axis_tdata,
  input  logic                                  s_axis_tuser,
  // tdata: top_left_x, top_left_y, bottom_left_x, bottom_left_y,
  // bottom_right_x, bottom_right_y, top_right_x, top_right_y (22 bits each),
  // confidence_logit (20), kept_color (1), class_index (4), zero padding
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [drdf_pkg::OutDataWidth-1:0]     m_axis_tdata,
  // Configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [drdf_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [drdf_pkg::ValueWidth-1:0]       cfg_data_i
);

  localparam int unsigned VW = drdf_pkg::ValueWidth;
  localparam int unsigned RW = $bits(drdf_pkg::result_t);

  logic                 in_valid_q;
  logic signed [VW-1:0] in_value_q;
  logic                 in_first_q;
  logic                 advance;
  logic                 emit;
  drdf_pkg::cfg_t       cfg_q;
  drdf_pkg::result_t    result;
  drdf_pkg::result_t    out_q;
  logic                 out_valid_q;

  // The processing stage moves on when the result register is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_value_q <= s_axis_tdata[VW-1:0];
      in_first_q <= s_axis_tuser;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_threshold   <= '0;
      cfg_q.accept_enable    <= 1'b1;
      cfg_q.target_color     <= drdf_pkg::ColorBlue[0];
      cfg_q.swap_colors      <= 1'b0;
      cfg_q.scale_horizontal <= drdf_pkg::ScaleReset;
      cfg_q.scale_vertical   <= drdf_pkg::ScaleReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        drdf_pkg::CfgLogitThreshold: cfg_q.conf_threshold   <= cfg_data_i;
        drdf_pkg::CfgAcceptEnable:   cfg_q.accept_enable    <= cfg_data_i[0];
        drdf_pkg::CfgTargetColor:    cfg_q.target_color     <= cfg_data_i[0];
        drdf_pkg::CfgSwapColors:     cfg_q.swap_colors      <= cfg_data_i[0];
        drdf_pkg::CfgScaleHoriz:
          cfg_q.scale_horizontal <= cfg_data_i[drdf_pkg::ScaleWidth-1:0];
        drdf_pkg::CfgScaleVert:
          cfg_q.scale_vertical   <= cfg_data_i[drdf_pkg::ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  drdf_row_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .value_i      (in_value_q),
    .row_first_i  (in_first_q),
    .cfg_i        (cfg_q),
    .emit_o       (emit),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(drdf_pkg::OutDataWidth - RW)'(0), out_q};

`ifndef SYNTHESIS
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_value_q)
                                  && $stable(in_first_q)))
    else $error("waiting item lost or changed");

  a_out_only_from_core : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !advance) |=> !out_valid_q)
    else $error("result appeared without a processed item");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("item processed while the result register is stalled");
`endif

endmodule
